/* hdl/sws_pkg.sv */
package sws_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int MEAN_W     = 24;
  localparam int VAR_W      = 49;
  localparam int MAD_W      = 25;
  localparam int RANGE_W    = 24;
  localparam int DIFF_W     = 25;
  localparam int OUT_DATA_W = 176;

  // reset statistics: variance 1.0 (16 frac bits), mean abs deviation 1.0 (8 frac bits)
  localparam logic [VAR_W-1:0] VAR_RESET = 49'd65536;
  localparam logic [MAD_W-1:0] MAD_RESET = 25'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MSTART,
    ST_MEAN,
    ST_PASS,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

/* hdl/sliding_window_statistics_core.sv */
// Sliding-window statistics over the last WINDOW samples.
//
// Input stream (s_axis): one signed 24-bit sample per transfer, 8 fraction bits.
// Output stream (m_axis): one result per input transfer, in order. tuser
// carries window_full; tdata carries mean, variance, mean abs deviation,
// range, rise over the tracked minimum and step from the previous sample.
//
// Samples are held in a WINDOW-deep RAM (registered read). While the
// window fills, a sample steps through read old slot, write, output and the
// statistics fields stay at their reset values. Once full, every sample runs a
// read-modify-write of its slot, a mean divide, a pass over all WINDOW entries
// (one RAM read per cycle, 4-stage pipe: read, deviation, square, accumulate)
// and the variance / abs-deviation divides. One sample is in flight at a time;
// s_axis_tready is high only when idle.
//
// Reset clears the fill count, running sum and minimum and restores the held
// statistics; the RAM needs no clearing as an entry is only used once written.
// A stalled receiver holds the result in the output register; the core can
// take and process the next sample meanwhile and waits only to hand it over.
module sliding_window_statistics_core
  import sws_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata_i,   // [23:0] sample
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [23:0] window_mean, [72:24] window_variance, [97:73] mean_abs_deviation,
  // [121:98] window_range, [146:122] rise_over_min, [171:147] step_diff, rest 0
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [0:0]            m_axis_tuser_o    // [0] window_full
);

  localparam int LW    = $clog2(WINDOW);
  localparam int AW    = LW;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + LW;
  localparam int SQ_W  = VAR_W + LW;
  localparam int AB_W  = MAD_W + LW;
  localparam logic [AW-1:0]    LAST_SLOT = AW'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(WINDOW);

  state_e state_q, state_d;

  logic [CNT_W-1:0]           fill_q, fill_d;
  logic                       full_q, full_d;
  logic [AW-1:0]              slot_q, slot_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] tmin_q, tmin_d;
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic signed [MEAN_W-1:0]   mean_q, mean_d;
  logic [VAR_W-1:0]           var_q, var_d;
  logic [MAD_W-1:0]           mad_q, mad_d;
  logic [RANGE_W-1:0]         range_q, range_d;
  logic [CNT_W-1:0]           pass_cnt_q, pass_cnt_d;
  logic                       out_vld_q, out_vld_d;
  logic                       out_full_q;
  logic                       out_load;

  // per-item payload
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [DIFF_W-1:0]   step_q;
  logic signed [DIFF_W-1:0]   rise_q;
  logic                       rise_late_q;  // rise taken against the rescanned minimum

  // pass pipeline
  logic                       r_vld_q, a_vld_q, b_vld_q;
  logic [MAD_W-1:0]           m_q;
  logic [VAR_W-1:0]           prod_q;
  logic [SQ_W-1:0]            sq_acc_q;
  logic [AB_W-1:0]            ab_acc_q;
  logic signed [SAMPLE_W-1:0] lo_q, hi_q;

  // output register payload
  logic signed [MEAN_W-1:0]   o_mean_q;
  logic [VAR_W-1:0]           o_var_q;
  logic [MAD_W-1:0]           o_mad_q;
  logic [RANGE_W-1:0]         o_range_q;
  logic signed [DIFF_W-1:0]   o_rise_q;
  logic signed [DIFF_W-1:0]   o_step_q;

  // RAM
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic signed [SAMPLE_W-1:0] rd_s;

  // dividers
  logic                mdiv_start, sdiv_start;
  logic                mdiv_done, vdiv_done, adiv_done;
  logic [SUM_W-1:0]    mdiv_num, mdiv_quo;
  logic [SQ_W-1:0]     vdiv_quo;
  logic [AB_W-1:0]     adiv_quo;
  logic [MEAN_W-1:0]   mq;

  logic                       in_xfer;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic signed [DIFF_W-1:0]   dev;

  assign in_sample = $signed(s_axis_tdata_i);
  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign rd_s      = $signed(ram_rdata);
  assign mdiv_num  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign mq        = mdiv_quo[MEAN_W-1:0];

  sws_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sws_cdiv #(
    .NUM_W   (SUM_W),
    .DIVISOR (WINDOW)
  ) u_mdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdiv_start),
    .num_i   (mdiv_num),
    .done_o  (mdiv_done),
    .quo_o   (mdiv_quo)
  );

  sws_cdiv #(
    .NUM_W   (SQ_W),
    .DIVISOR (WINDOW)
  ) u_vdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sdiv_start),
    .num_i   (sq_acc_q),
    .done_o  (vdiv_done),
    .quo_o   (vdiv_quo)
  );

  sws_cdiv #(
    .NUM_W   (AB_W),
    .DIVISOR (WINDOW)
  ) u_adiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sdiv_start),
    .num_i   (ab_acc_q),
    .done_o  (adiv_done),
    .quo_o   (adiv_quo)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    full_d     = full_q;
    slot_d     = slot_q;
    sum_d      = sum_q;
    tmin_d     = tmin_q;
    prev_d     = prev_q;
    mean_d     = mean_q;
    var_d      = var_q;
    mad_d      = mad_q;
    range_d    = range_q;
    pass_cnt_d = pass_cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = slot_q;
    mdiv_start = 1'b0;
    sdiv_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          // fetch the entry about to be overwritten
          ram_re = 1'b1;
          prev_d = in_sample;
          if (fill_q == '0) begin
            tmin_d = in_sample;
          end
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        ram_we = 1'b1;
        slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
        if (full_q) begin
          sum_d   = sum_q + {{LW{sample_q[SAMPLE_W-1]}}, sample_q}
                          - {{LW{rd_s[SAMPLE_W-1]}}, rd_s};
          state_d = ST_MSTART;
        end else begin
          sum_d  = sum_q + {{LW{sample_q[SAMPLE_W-1]}}, sample_q};
          fill_d = fill_q + 1'b1;
          if (fill_q == CNT_LAST) begin
            full_d  = 1'b1;
            state_d = ST_MSTART;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_MSTART: begin
        mdiv_start = 1'b1;
        state_d    = ST_MEAN;
      end
      ST_MEAN: begin
        if (mdiv_done) begin
          // truncate toward zero: divide the magnitude, restore the sign
          mean_d     = sum_q[SUM_W-1] ? $signed(-mq) : $signed(mq);
          pass_cnt_d = '0;
          state_d    = ST_PASS;
        end
      end
      ST_PASS: begin
        if (pass_cnt_q != CNT_FULL) begin
          ram_re     = 1'b1;
          ram_raddr  = pass_cnt_q[AW-1:0];
          pass_cnt_d = pass_cnt_q + 1'b1;
        end else if (!r_vld_q && !a_vld_q && !b_vld_q) begin
          sdiv_start = 1'b1;
          tmin_d     = lo_q;
          range_d    = RANGE_W'(hi_q - lo_q);
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        // the variance divide never finishes before the abs-deviation divide
        if (vdiv_done) begin
          var_d   = vdiv_quo[VAR_W-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (adiv_done) begin
      mad_d = adiv_quo[MAD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      full_q     <= 1'b0;
      slot_q     <= '0;
      sum_q      <= '0;
      tmin_q     <= '0;
      prev_q     <= '0;
      mean_q     <= '0;
      var_q      <= VAR_RESET;
      mad_q      <= MAD_RESET;
      range_q    <= '0;
      pass_cnt_q <= '0;
      out_vld_q  <= 1'b0;
      out_full_q <= 1'b0;
      r_vld_q    <= 1'b0;
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      full_q     <= full_d;
      slot_q     <= slot_d;
      sum_q      <= sum_d;
      tmin_q     <= tmin_d;
      prev_q     <= prev_d;
      mean_q     <= mean_d;
      var_q      <= var_d;
      mad_q      <= mad_d;
      range_q    <= range_d;
      pass_cnt_q <= pass_cnt_d;
      out_vld_q  <= out_vld_d;
      r_vld_q    <= ram_re && (state_q == ST_PASS);
      a_vld_q    <= r_vld_q;
      b_vld_q    <= a_vld_q;
      if (out_load) begin
        out_full_q <= full_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  assign dev = {rd_s[SAMPLE_W-1], rd_s} - {mean_q[MEAN_W-1], mean_q};

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= in_sample;
      step_q   <= (fill_q == '0) ? '0
                : {in_sample[SAMPLE_W-1], in_sample} - {prev_q[SAMPLE_W-1], prev_q};
    end

    // rise over min: before the recompute while filling (the sample that
    // fills the window included), after it once full
    if (state_q == ST_UPD) begin
      rise_late_q <= full_q;
    end
    if (state_q == ST_UPD && !full_q) begin
      rise_q <= {sample_q[SAMPLE_W-1], sample_q} - {tmin_q[SAMPLE_W-1], tmin_q};
    end else if (sdiv_start && rise_late_q) begin
      rise_q <= {sample_q[SAMPLE_W-1], sample_q} - {lo_q[SAMPLE_W-1], lo_q};
    end

    // pass pipeline: deviation, square, accumulate
    if (state_q == ST_MEAN && mdiv_done) begin
      sq_acc_q <= '0;
      ab_acc_q <= '0;
      lo_q     <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      hi_q     <= {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      if (r_vld_q) begin
        m_q <= dev[DIFF_W-1] ? MAD_W'(-dev) : MAD_W'(dev);
        if (rd_s < lo_q) begin
          lo_q <= rd_s;
        end
        if (rd_s > hi_q) begin
          hi_q <= rd_s;
        end
      end
      if (a_vld_q) begin
        prod_q   <= VAR_W'(m_q * m_q);
        ab_acc_q <= ab_acc_q + AB_W'(m_q);
      end
      if (b_vld_q) begin
        sq_acc_q <= sq_acc_q + SQ_W'(prod_q);
      end
    end

    if (out_load) begin
      o_mean_q  <= mean_q;
      o_var_q   <= var_q;
      o_mad_q   <= mad_q;
      o_range_q <= range_q;
      o_rise_q  <= rise_q;
      o_step_q  <= step_q;
    end
  end

  assign s_axis_tready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tuser_o[0] = out_full_q;
  assign m_axis_tdata_o    = {4'b0000, o_step_q, o_rise_q, o_range_q, o_mad_q, o_var_q,
                              o_mean_q};

endmodule

/* hdl/sws_ram.sv */
module sws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sws_cdiv.sv */
// Unsigned divide by a constant. Power-of-two divisors use a registered shift;
// others run a long division, 8 quotient bits per cycle.
module sws_cdiv #(
  parameter int NUM_W   = 27,
  parameter int DIVISOR = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);

  if (IS_POW2) begin : g_shift
    localparam int SH = $clog2(DIVISOR);

    logic             done_q;
    logic [NUM_W-1:0] quo_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        quo_q <= num_i >> SH;
      end
    end

    assign done_o = done_q;
    assign quo_o  = quo_q;

  end else begin : g_long
    localparam int STEPS = (NUM_W + 7) / 8;
    localparam int PAD_W = STEPS * 8;
    localparam int RW    = $clog2(DIVISOR) + 1;
    localparam int CW    = $clog2(STEPS + 1);
    localparam logic [RW-1:0] DIV_R = RW'(DIVISOR);

    logic [PAD_W-1:0] num_q, num_d;
    logic [RW-1:0]    rem_q, rem_d;
    logic [CW-1:0]    cnt_q;
    logic             done_q;

    // 8 restoring steps; quotient bits shift in at the bottom of num
    always_comb begin
      num_d = num_q;
      rem_d = rem_q;
      for (int i = 0; i < 8; i++) begin
        rem_d = {rem_d[RW-2:0], num_d[PAD_W-1]};
        num_d = {num_d[PAD_W-2:0], 1'b0};
        if (rem_d >= DIV_R) begin
          rem_d    = rem_d - DIV_R;
          num_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cnt_q  <= '0;
        done_q <= 1'b0;
      end else if (start_i) begin
        cnt_q  <= CW'(STEPS);
        done_q <= 1'b0;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CW'(1));
      end else begin
        done_q <= 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        num_q <= PAD_W'(num_i);
        rem_q <= '0;
      end else if (cnt_q != '0) begin
        num_q <= num_d;
        rem_q <= rem_d;
      end
    end

    assign done_o = done_q;
    assign quo_o  = num_q[NUM_W-1:0];
  end

endmodule

/* hdl/sws_chk.sv */
module sws_chk
  import sws_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [SAMPLE_W-1:0]   s_axis_tdata_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]            m_axis_tuser_o
);

  // output held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed during stall");

  // one sample in flight: no transfer right after a transfer
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted back to back");

  // window_full never drops once reported
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(m_axis_tuser_o[0]))
    else $error("window_full dropped");

  // before the window fills the statistics sit at their reset values
  a_fill_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      m_axis_tdata_o[23:0] == '0 && m_axis_tdata_o[72:24] == VAR_RESET &&
      m_axis_tdata_o[97:73] == MAD_RESET && m_axis_tdata_o[121:98] == '0)
    else $error("statistics not at reset during fill");

endmodule

bind sliding_window_statistics_core sws_chk u_sws_chk (.*);
